// ----- hw/rtl/drts_pkg.sv -----
`default_nettype none

package drts_pkg;

   // Press qualification phases
   typedef enum logic [1:0] {
      PH_WAIT = 2'd0,
      PH_DOWN = 2'd1,
      PH_CONF = 2'd2,
      PH_REP  = 2'd3
   } drts_phase_type;

   // Time field chosen for adjustment
   typedef enum logic [1:0] {
      FIELD_NONE   = 2'd0,
      FIELD_HOUR   = 2'd1,
      FIELD_MINUTE = 2'd2,
      FIELD_SECOND = 2'd3
   } drts_field_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      REG_CONFIRM_TICKS = 2'd0,
      REG_REPEAT_DELAY  = 2'd1,
      REG_REPEAT_PERIOD = 2'd2,
      REG_FIELD_SELECT  = 2'd3
   } drts_reg_type;

   localparam int unsigned TICK_W    = 8;
   localparam int unsigned BUTTONS_W = 3;
   localparam int unsigned HOUR_W    = 5;
   localparam int unsigned MINUTE_W  = 6;
   localparam int unsigned SECOND_W  = 6;

   localparam logic [TICK_W-1:0] CONFIRM_RESET = 8'd2;
   localparam logic [TICK_W-1:0] DELAY_RESET   = 8'd80;
   localparam logic [TICK_W-1:0] PERIOD_RESET  = 8'd20;

   localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
   localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;
   localparam logic [SECOND_W-1:0] SECOND_MAX = 6'd59;

   // Button bit positions (active low)
   localparam int unsigned BTN_HOUR   = 0;
   localparam int unsigned BTN_MINUTE = 1;
   localparam int unsigned BTN_SECOND = 2;

   // Tick thresholds seen by the press controller
   typedef struct packed {
      logic [TICK_W-1:0] confirm_ticks;
      logic [TICK_W-1:0] repeat_delay_ticks;
      logic [TICK_W-1:0] repeat_period_ticks;
   } drts_thresh_type;

   // Press controller status toward the time counters and result stage
   typedef struct packed {
      drts_phase_type phase_next;
      logic           attempt;
   } drts_ctrl_type;

endpackage

`default_nettype wire

// ----- hw/rtl/drts_ctrl.sv -----
`default_nettype none

module drts_ctrl (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  beat,
   input  wire logic [drts_pkg::BUTTONS_W-1:0]        buttons_n,
   input  wire drts_pkg::drts_thresh_type             thresh,
   output drts_pkg::drts_ctrl_type                    status
);
   import drts_pkg::*;

   drts_phase_type      phase_ff, phase_in;
   logic [TICK_W-1:0]   tick_ff, tick_in;
   logic [TICK_W-1:0]   tick_inc;
   logic                down;
   logic                hit_confirm;
   logic                hit_delay;
   logic                hit_period;

   assign down        = (buttons_n != {BUTTONS_W{1'b1}});
   assign tick_inc    = tick_ff + 1'b1;
   assign hit_confirm = (tick_inc == thresh.confirm_ticks);
   assign hit_delay   = (tick_inc == thresh.repeat_delay_ticks);
   assign hit_period  = (tick_inc == thresh.repeat_period_ticks);

   // Next phase and tick count
   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      unique case (phase_ff)
         PH_WAIT: begin
            if (down) begin
               phase_in = PH_DOWN;
               tick_in  = '0;
            end
         end
         PH_DOWN: begin
            // confirm wins over a release
            tick_in = tick_inc;
            if (hit_confirm) begin
               phase_in = PH_CONF;
               tick_in  = '0;
            end else if (!down) begin
               phase_in = PH_WAIT;
            end
         end
         PH_CONF: begin
            tick_in = tick_inc;
            if (!down) begin
               phase_in = PH_WAIT;
            end else if (hit_delay) begin
               phase_in = PH_REP;
               tick_in  = '0;
            end
         end
         PH_REP: begin
            // period check comes before the release
            tick_in = tick_inc;
            if (hit_period) begin
               tick_in = '0;
            end else if (!down) begin
               phase_in = PH_WAIT;
            end
         end
         default: begin
            phase_in = PH_WAIT;
         end
      endcase
   end

   // Increment attempt and status
   always_comb begin
      status.phase_next = phase_in;
      status.attempt    = ((phase_ff == PH_DOWN) && hit_confirm) ||
                          ((phase_ff == PH_REP) && hit_period);
   end

   // Advance state on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         tick_ff  <= '0;
      end else if (beat) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/drts_time.sv -----
`default_nettype none

module drts_time (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  beat,
   input  wire logic [drts_pkg::BUTTONS_W-1:0]        buttons_n,
   input  wire drts_pkg::drts_field_type              field_select,
   input  wire drts_pkg::drts_ctrl_type               status,
   output logic [drts_pkg::HOUR_W-1:0]                hour_next,
   output logic [drts_pkg::MINUTE_W-1:0]              minute_next,
   output logic [drts_pkg::SECOND_W-1:0]              second_next
);
   import drts_pkg::*;

   logic [HOUR_W-1:0]   hours_ff, hours_in;
   logic [MINUTE_W-1:0] minutes_ff, minutes_in;
   logic [SECOND_W-1:0] seconds_ff, seconds_in;

   // Bump the selected field if its own button is held
   always_comb begin
      hours_in   = hours_ff;
      minutes_in = minutes_ff;
      seconds_in = seconds_ff;
      if (status.attempt) begin
         unique case (field_select)
            FIELD_HOUR: begin
               if (!buttons_n[BTN_HOUR]) begin
                  hours_in = (hours_ff >= HOUR_MAX) ? '0 : hours_ff + 1'b1;
               end
            end
            FIELD_MINUTE: begin
               if (!buttons_n[BTN_MINUTE]) begin
                  minutes_in = (minutes_ff >= MINUTE_MAX) ? '0 : minutes_ff + 1'b1;
               end
            end
            FIELD_SECOND: begin
               if (!buttons_n[BTN_SECOND]) begin
                  seconds_in = (seconds_ff >= SECOND_MAX) ? '0 : seconds_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign hour_next   = hours_in;
   assign minute_next = minutes_in;
   assign second_next = seconds_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         hours_ff   <= '0;
         minutes_ff <= '0;
         seconds_ff <= '0;
      end else if (beat) begin
         hours_ff   <= hours_in;
         minutes_ff <= minutes_in;
         seconds_ff <= seconds_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/debounced_repeat_time_setter.sv -----
// Channel   Direction  Beat contents
// req_      in         tdata[2:0] buttons_n (active low)
// rsp_      out        tdata[19:0] hour, minute, second, phase, bumped
// csr_      in         write enable, register index, 8-bit data
//
// Each accepted request beat gives one registered response beat in the next cycle.
// One beat per cycle sustained: the press FSM, tick compare and field wrap sit
// in a single stage between the state registers and the response register.
// Reset (synchronous, active high) returns phase, counters and time to zero and
// config to its defaults. A stalled response holds; req_tready follows rsp_tready.
`default_nettype none

module debounced_repeat_time_setter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [2:0] buttons_n, [7:3] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [4:0] hour_now, [10:5] minute_now,
                                         // [16:11] second_now, [18:17] press_phase,
                                         // [19] bumped, [23:20] zero
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [7:0]  csr_wdata
);
   import drts_pkg::*;

   logic [TICK_W-1:0]        confirm_ff;
   logic [TICK_W-1:0]        delay_ff;
   logic [TICK_W-1:0]        period_ff;
   drts_field_type           field_ff;
   drts_thresh_type          thresh;
   drts_ctrl_type            status;
   logic                     beat;
   logic [BUTTONS_W-1:0]     buttons_n;
   logic [HOUR_W-1:0]        hour_next;
   logic [MINUTE_W-1:0]      minute_next;
   logic [SECOND_W-1:0]      second_next;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [23:0]              rsp_data_ff, rsp_data_in;

   assign buttons_n  = req_tdata[BUTTONS_W-1:0];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign beat       = req_tvalid && req_tready;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         confirm_ff <= CONFIRM_RESET;
         delay_ff   <= DELAY_RESET;
         period_ff  <= PERIOD_RESET;
         field_ff   <= FIELD_NONE;
      end else if (csr_we) begin
         unique case (drts_reg_type'(csr_addr))
            REG_CONFIRM_TICKS: confirm_ff <= csr_wdata;
            REG_REPEAT_DELAY:  delay_ff   <= csr_wdata;
            REG_REPEAT_PERIOD: period_ff  <= csr_wdata;
            REG_FIELD_SELECT:  field_ff   <= drts_field_type'(csr_wdata[1:0]);
            default: begin
            end
         endcase
      end
   end

   assign thresh.confirm_ticks       = confirm_ff;
   assign thresh.repeat_delay_ticks  = delay_ff;
   assign thresh.repeat_period_ticks = period_ff;

   drts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .beat      (beat),
      .buttons_n (buttons_n),
      .thresh    (thresh),
      .status    (status)
   );

   drts_time u_time (
      .clock        (clock),
      .reset        (reset),
      .beat         (beat),
      .buttons_n    (buttons_n),
      .field_select (field_ff),
      .status       (status),
      .hour_next    (hour_next),
      .minute_next  (minute_next),
      .second_next  (second_next)
   );

   // Response register: load on accept, drop valid once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (beat) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'b0000, status.attempt, status.phase_next,
                         second_next, minute_next, hour_next};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- tb/sv/debounced_repeat_time_setter_test.sv -----
`default_nettype none

module debounced_repeat_time_setter_test;
   timeunit 1ns;
   timeprecision 1ps;

   import drts_pkg::*;

   localparam int CYCLE_LIMIT = 100000;
   localparam int RANDOM_PHASES = 10;

   // One response beat as seen by the checker
   typedef struct packed {
      logic [HOUR_W-1:0]   hour_now;
      logic [MINUTE_W-1:0] minute_now;
      logic [SECOND_W-1:0] second_now;
      drts_phase_type      press_phase;
      logic                bumped;
   } readout_type;

   typedef enum logic {ROW_TICK, ROW_CSR} row_kind_type;

   // Directed script row: either a register write or one button tick
   typedef struct packed {
      row_kind_type      kind;
      drts_reg_type      reg_id;
      logic [7:0]        value;
      logic [BUTTONS_W-1:0] buttons;
      logic              known;
      readout_type       want;
   } script_row_type;

   localparam readout_type NO_VIEW = '0;

   // Starts from reset settings: confirm 2, delay 80, period 20, no field
   localparam script_row_type SCRIPT [32] = '{
      // all up, then a press confirmed while no field is selected
      '{ROW_TICK, REG_CONFIRM_TICKS, 8'd0, 3'b111, 1'b1, '{5'd0, 6'd0, 6'd0, PH_WAIT, 1'b0}},
      '{ROW_TICK, REG_CONFIRM_TICKS, 8'd0, 3'b000, 1'b1, '{5'd0, 6'd0, 6'd0, PH_DOWN, 1'b0}},
      '{ROW_TICK, REG_CONFIRM_TICKS, 8'd0, 3'b000, 1'b1, '{5'd0, 6'd0, 6'd0, PH_DOWN, 1'b0}},
      '{ROW_TICK, REG_CONFIRM_TICKS, 8'd0, 3'b000, 1'b1, '{5'd0, 6'd0, 6'd0, PH_CONF, 1'b1}},
      '{ROW_TICK, REG_CONFIRM_TICKS, 8'd0, 3'b111, 1'b1, '{5'd0, 6'd0, 6'd0, PH_WAIT, 1'b0}},
      // shortest thresholds on the hour field
      '{ROW_CSR, REG_CONFIRM_TICKS, 8'd1, 3'b111, 1'b0, NO_VIEW},
      '{ROW_CSR, REG_REPEAT_DELAY, 8'd1, 3'b111, 1'b0, NO_VIEW},
      '{ROW_CSR, REG_REPEAT_PERIOD, 8'd1, 3'b111, 1'b0, NO_VIEW},
      '{ROW_CSR, REG_FIELD_SELECT, 8'(FIELD_HOUR), 3'b111, 1'b0, NO_VIEW},
      // confirm wins over a release in the down phase
      '{ROW_TICK, REG_CONFIRM_TICKS, 8'd0, 3'b110, 1'b1, '{5'd0, 6'd0, 6'd0, PH_DOWN, 1'b0}},
      '{ROW_TICK, REG_CONFIRM_TICKS, 8'd0, 3'b111, 1'b1, '{5'd0, 6'd0, 6'd0, PH_CONF, 1'b1}},
      '{ROW_TICK, REG_CONFIRM_TICKS, 8'd0, 3'b110, 1'b1, '{5'd0, 6'd0, 6'd0, PH_REP, 1'b0}},
      '{ROW_TICK, REG_CONFIRM_TICKS, 8'd0, 3'b110, 1'b1, '{5'd1, 6'd0, 6'd0, PH_REP, 1'b1}},
      // period check before release: attempt with all buttons up
      '{ROW_TICK, REG_CONFIRM_TICKS, 8'd0, 3'b111, 1'b1, '{5'd1, 6'd0, 6'd0, PH_REP, 1'b1}},
      '{ROW_CSR, REG_REPEAT_PERIOD, 8'd2, 3'b111, 1'b0, NO_VIEW},
      '{ROW_CSR, REG_FIELD_SELECT, 8'(FIELD_MINUTE), 3'b111, 1'b0, NO_VIEW},
      '{ROW_TICK, REG_CONFIRM_TICKS, 8'd0, 3'b111, 1'b1, '{5'd1, 6'd0, 6'd0, PH_WAIT, 1'b0}},
      '{ROW_TICK, REG_CONFIRM_TICKS, 8'd0, 3'b101, 1'b1, '{5'd1, 6'd0, 6'd0, PH_DOWN, 1'b0}},
      '{ROW_TICK, REG_CONFIRM_TICKS, 8'd0, 3'b101, 1'b1, '{5'd1, 6'd1, 6'd0, PH_CONF, 1'b1}},
      '{ROW_TICK, REG_CONFIRM_TICKS, 8'd0, 3'b101, 1'b1, '{5'd1, 6'd1, 6'd0, PH_REP, 1'b0}},
      '{ROW_TICK, REG_CONFIRM_TICKS, 8'd0, 3'b101, 1'b1, '{5'd1, 6'd1, 6'd0, PH_REP, 1'b0}},
      '{ROW_TICK, REG_CONFIRM_TICKS, 8'd0, 3'b100, 1'b1, '{5'd1, 6'd2, 6'd0, PH_REP, 1'b1}},
      '{ROW_CSR, REG_FIELD_SELECT, 8'(FIELD_SECOND), 3'b111, 1'b0, NO_VIEW},
      '{ROW_TICK, REG_CONFIRM_TICKS, 8'd0, 3'b011, 1'b1, '{5'd1, 6'd2, 6'd0, PH_REP, 1'b0}},
      '{ROW_TICK, REG_CONFIRM_TICKS, 8'd0, 3'b011, 1'b1, '{5'd1, 6'd2, 6'd1, PH_REP, 1'b1}},
      '{ROW_TICK, REG_CONFIRM_TICKS, 8'd0, 3'b000, 1'b0, NO_VIEW},
      '{ROW_TICK, REG_CONFIRM_TICKS, 8'd0, 3'b000, 1'b0, NO_VIEW},
      '{ROW_TICK, REG_CONFIRM_TICKS, 8'd0, 3'b111, 1'b0, NO_VIEW},
      // hour selected but only other buttons down: attempt changes nothing
      '{ROW_CSR, REG_FIELD_SELECT, 8'(FIELD_HOUR), 3'b111, 1'b0, NO_VIEW},
      '{ROW_TICK, REG_CONFIRM_TICKS, 8'd0, 3'b101, 1'b0, NO_VIEW},
      '{ROW_TICK, REG_CONFIRM_TICKS, 8'd0, 3'b101, 1'b1, '{5'd1, 6'd2, 6'd2, PH_CONF, 1'b1}},
      '{ROW_TICK, REG_CONFIRM_TICKS, 8'd0, 3'b111, 1'b0, NO_VIEW}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;   // [2:0] buttons_n, [7:3] zero
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [4:0] hour_now, [10:5] minute_now,
                                   // [16:11] second_now, [18:17] press_phase,
                                   // [19] bumped, [23:20] zero
   logic       csr_we = 1'b0;
   logic [1:0] csr_addr = 2'd0;
   logic [7:0] csr_wdata = 8'd0;

   // Directed rows with a typed-in readout travel beside the request beat
   logic        tick_known = 1'b0;
   readout_type tick_want = '0;

   int sender_idle_pct = 0;
   int stall_pct = 0;
   int mismatches = 0;
   int ticks_sent = 0;
   int readouts_seen = 0;
   int cycles = 0;

   // Shadow of the setter state and its registers
   drts_phase_type      ph_state;
   logic [TICK_W-1:0]   press_ticks;
   logic [HOUR_W-1:0]   hour_reg;
   logic [MINUTE_W-1:0] minute_reg;
   logic [SECOND_W-1:0] second_reg;
   logic [TICK_W-1:0]   confirm_lim, delay_lim, period_lim;
   drts_field_type      field_sel;

   readout_type pending_readouts [$];

   debounced_repeat_time_setter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Advance the selected field if its own button is down
   function automatic void bump_field(input logic [BUTTONS_W-1:0] btn);
      if (!btn[BTN_HOUR] && field_sel == FIELD_HOUR) begin
         hour_reg = (hour_reg == HOUR_MAX) ? '0 : hour_reg + 1'b1;
      end else if (!btn[BTN_MINUTE] && field_sel == FIELD_MINUTE) begin
         minute_reg = (minute_reg == MINUTE_MAX) ? '0 : minute_reg + 1'b1;
      end else if (!btn[BTN_SECOND] && field_sel == FIELD_SECOND) begin
         second_reg = (second_reg == SECOND_MAX) ? '0 : second_reg + 1'b1;
      end
   endfunction

   // One tick of the press machine; returns the readout it produces
   function automatic readout_type advance_setter(input logic [BUTTONS_W-1:0] btn);
      logic        down;
      logic        tried;
      readout_type view;
      down  = (btn != 3'b111);
      tried = 1'b0;
      case (ph_state)
         PH_WAIT: begin
            if (down) begin
               ph_state    = PH_DOWN;
               press_ticks = '0;
            end
         end
         PH_DOWN: begin
            press_ticks = press_ticks + 1'b1;
            if (!down) ph_state = PH_WAIT;
            // reaching the threshold overrides a release
            if (press_ticks == confirm_lim) begin
               ph_state    = PH_CONF;
               bump_field(btn);
               tried       = 1'b1;
               press_ticks = '0;
            end
         end
         PH_CONF: begin
            press_ticks = press_ticks + 1'b1;
            if (!down) begin
               ph_state = PH_WAIT;
            end else if (press_ticks == delay_lim) begin
               ph_state    = PH_REP;
               press_ticks = '0;
            end
         end
         default: begin
            press_ticks = press_ticks + 1'b1;
            // period check comes before the release check
            if (press_ticks == period_lim) begin
               press_ticks = '0;
               bump_field(btn);
               tried = 1'b1;
            end else if (!down) begin
               ph_state = PH_WAIT;
            end
         end
      endcase
      view.hour_now    = hour_reg;
      view.minute_now  = minute_reg;
      view.second_now  = second_reg;
      view.press_phase = ph_state;
      view.bumped      = tried;
      return view;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Score response beats, track register writes, predict accepted ticks
   always @(posedge clock) begin : watch
      readout_type want;
      readout_type seen;
      if (reset) begin
         ph_state    = PH_WAIT;
         press_ticks = '0;
         hour_reg    = '0;
         minute_reg  = '0;
         second_reg  = '0;
         confirm_lim = CONFIRM_RESET;
         delay_lim   = DELAY_RESET;
         period_lim  = PERIOD_RESET;
         field_sel   = FIELD_NONE;
         pending_readouts.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            readouts_seen++;
            if (pending_readouts.size() == 0) begin
               $error("response beat with no readout pending: %h", rsp_tdata);
               mismatches++;
            end else begin
               want = pending_readouts.pop_front();
               seen = {rsp_tdata[4:0], rsp_tdata[10:5], rsp_tdata[16:11],
                       drts_phase_type'(rsp_tdata[18:17]), rsp_tdata[19]};
               check_field("hour_now", want.hour_now, seen.hour_now);
               check_field("minute_now", want.minute_now, seen.minute_now);
               check_field("second_now", want.second_now, seen.second_now);
               check_field("press_phase", want.press_phase, seen.press_phase);
               check_field("bumped", want.bumped, seen.bumped);
            end
         end
         if (csr_we) begin
            case (drts_reg_type'(csr_addr))
               REG_CONFIRM_TICKS: confirm_lim = csr_wdata;
               REG_REPEAT_DELAY:  delay_lim   = csr_wdata;
               REG_REPEAT_PERIOD: period_lim  = csr_wdata;
               default:           field_sel   = drts_field_type'(csr_wdata[1:0]);
            endcase
         end
         if (req_tvalid && req_tready) begin
            want = advance_setter(req_tdata[BUTTONS_W-1:0]);
            if (tick_known) want = tick_want;
            pending_readouts.push_back(want);
         end
      end
   end

   // Random backpressure on the response side
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Offer one tick beat, with random idle cycles ahead of it
   task automatic send_tick(input logic [BUTTONS_W-1:0] btn, input logic known,
                            input readout_type want);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, btn};
      tick_known <= known;
      tick_want  <= want;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ticks_sent++;
   endtask

   // Drop valid and wait for every readout to come back
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_readouts.size() != 0) @(posedge clock);
   endtask

   // Caller lowers csr_we after the last write of a batch
   task automatic write_reg(input drts_reg_type id, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= id;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   initial begin : stimulus
      int             r, ph, budget, span, start, runs, k, n;
      logic [7:0]     c, d, p;
      drts_field_type f;
      logic [2:0]     pattern, btn;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed script
      for (r = 0; r < $size(SCRIPT); r++) begin
         if (SCRIPT[r].kind == ROW_CSR) begin
            settle();
            write_reg(SCRIPT[r].reg_id, SCRIPT[r].value);
            csr_we <= 1'b0;
         end else begin
            send_tick(SCRIPT[r].buttons, SCRIPT[r].known, SCRIPT[r].want);
         end
      end

      // Random phases, each with its own thresholds and pacing
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            // period 1 locks the repeat phase: drive each field through its wrap
            0: begin c = 8'd1; d = 8'd1; p = 8'd1; f = FIELD_MINUTE; budget = 70; end
            1: begin c = 8'd1; d = 8'd1; p = 8'd1; f = FIELD_SECOND; budget = 70; end
            2: begin c = 8'd1; d = 8'd1; p = 8'd1; f = FIELD_HOUR;   budget = 30; end
            // widest thresholds
            3: begin c = 8'd255; d = 8'd255; p = 8'd255; f = FIELD_SECOND; budget = 700; end
            // zero confirm threshold wraps the tick counter
            4: begin c = 8'd0; d = 8'd1; p = 8'd2; f = FIELD_HOUR; budget = 200; end
            default: begin
               c = 8'($urandom_range(1, 6));
               d = 8'($urandom_range(1, 6));
               p = 8'($urandom_range(2, 5));
               f = drts_field_type'($urandom_range(0, 3));
               budget = 15;
            end
         endcase
         case (ph % 4)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 76; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 76; end
            default: begin sender_idle_pct = 27; stall_pct = 27; end
         endcase

         settle();
         write_reg(REG_CONFIRM_TICKS, c);
         write_reg(REG_REPEAT_DELAY, d);
         write_reg(REG_REPEAT_PERIOD, p);
         write_reg(REG_FIELD_SELECT, 8'(f));
         csr_we <= 1'b0;

         span = (c == 0 ? 256 : int'(c)) + (d == 0 ? 256 : int'(d))
              + (p == 0 ? 256 : int'(p)) + 3;
         // hold the whole budget in one press so the field wraps
         if (ph < 3) span = budget;
         start = ticks_sent;
         runs  = 0;
         while (ticks_sent - start < budget) begin
            if (runs > 0 && $urandom_range(0, 9) == 0) begin
               // noise burst
               n = $urandom_range(1, 6);
               repeat (n) send_tick(3'($urandom_range(0, 7)), 1'b0, NO_VIEW);
            end else begin
               // release, then hold a press, often long enough to reach repeats
               pattern = 3'($urandom_range(0, 6));
               // field codes 1..3 map to button bits 0..2
               if (f != FIELD_NONE && (runs == 0 || $urandom_range(0, 99) < 60)) begin
                  pattern[int'(f) - 1] = 1'b0;
               end
               n = $urandom_range(1, 3);
               repeat (n) send_tick(3'b111, 1'b0, NO_VIEW);
               n = (runs == 0 || $urandom_range(0, 1) == 1) ? span : $urandom_range(1, span);
               for (k = 0; k < n; k++) begin
                  btn = pattern;
                  if (runs > 0 && $urandom_range(0, 99) < 8) btn = 3'($urandom_range(0, 7));
                  send_tick(btn, 1'b0, NO_VIEW);
               end
            end
            runs++;
         end
      end

      settle();
      repeat (4) @(posedge clock);
      $display("Covered %0d button ticks (%0d response beats): directed script plus %0d",
               ticks_sent, readouts_seen, RANDOM_PHASES);
      $display("random threshold settings, incl. 255 and 0, under four pacing modes");
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- debounced_repeat_time_setter.f -----
hw/rtl/drts_pkg.sv
hw/rtl/drts_ctrl.sv
hw/rtl/drts_time.sv
hw/rtl/debounced_repeat_time_setter.sv
tb/sv/debounced_repeat_time_setter_test.sv
